@@ rtl/orbit_point_velocity_law_top_defines.svh @@
// assertion macros for the orbit point velocity law block
`ifndef ORBIT_POINT_VELOCITY_LAW_TOP_DEFINES_SVH
`define ORBIT_POINT_VELOCITY_LAW_TOP_DEFINES_SVH

// checked only outside reset
`define OPVL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked in and out of reset
`define OPVL_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ rtl/opvl_pkg.sv @@
// types, constants and tables of the orbit point velocity law block
`timescale 1ns / 1ps
package opvl_pkg;

  localparam int COORD_WIDTH   = 16;
  localparam int CORDIC_STAGES = 16;
  localparam int CORDIC_SHIFT  = 30 - COORD_WIDTH;
  localparam int D_W    = COORD_WIDTH + 1;
  localparam int MAG_W  = COORD_WIDTH + 1;
  localparam int XY_W   = 34;
  localparam int QB     = 18;
  localparam int REM_W  = COORD_WIDTH + 19;
  localparam int UX_W   = QB + 1;
  localparam int ADDR_W = 5;

  localparam logic [29:0] INV_GAIN_Q30 = 30'd652032875;
  localparam logic [11:0] TANG_SPEED_K = 12'd3770;
  localparam int MAG_SH = 30 + CORDIC_SHIFT;

  localparam logic signed [COORD_WIDTH-1:0] CENTRE_RST = '0;
  localparam logic signed [15:0] GOAL_RST = 16'sd0;
  localparam logic [15:0] GAIN_RST = 16'd7680;
  localparam logic [14:0] MAXS_RST = 15'd500;
  localparam logic [14:0] TOL_RST  = 15'd1043;

  // stage numbers
  localparam int ST_P1 = CORDIC_STAGES + 1;
  localparam int ST_P2 = CORDIC_STAGES + 2;
  localparam int ST_P3 = CORDIC_STAGES + 3;
  localparam int ST_M1 = ST_P3 + QB + 1;
  localparam int ST_M2 = ST_M1 + 1;
  localparam int ST_M3 = ST_M1 + 2;
  localparam int NST   = ST_M3 + 1;

  localparam logic [31:0] ATAN_TURNS [24] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81};

  typedef enum logic [2:0] {
    REG_CENTRE_X = 3'd0,
    REG_CENTRE_Y = 3'd1,
    REG_GOAL     = 3'd2,
    REG_GAIN     = 3'd3,
    REG_MAXS     = 3'd4,
    REG_TOL      = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] robot_x;
    logic signed [COORD_WIDTH-1:0] robot_y;
  } in_t;

  typedef struct packed {
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] heading;
    logic               done_res;
  } out_t;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic [31:0]            acc;
    logic signed [D_W-1:0]  dx;
    logic signed [D_W-1:0]  dy;
    logic                   zero;
  } cor_t;

  typedef struct packed {
    logic [REM_W-1:0]        rem_x;
    logic [REM_W-1:0]        rem_y;
    logic [QB-1:0]           q_x;
    logic [QB-1:0]           q_y;
    logic [MAG_W-1:0]        mag;
    logic                    sx;
    logic                    sy;
    logic signed [MAG_W:0]   diff;
    logic [14:0]             spd;
    logic                    eneg;
    logic [15:0]             heading;
    logic                    done;
    logic                    zero;
  } div_t;

endpackage

@@ rtl/orbit_point_velocity_law_top.sv @@
// orbit point velocity law: cordic bearing and distance, unit vector divide, velocity mix
`timescale 1ns / 1ps
//  channel  | handshake                | payload
//  input    | in_valid_i / in_ready_o  | in_data_i  (robot_x, robot_y)
//  output   | out_valid_o / out_ready_i| out_data_o (vel_x, vel_y, heading, done_res)
//  config   | psel penable pwrite      | paddr, pwdata, prdata (pready tied high)
// one item per cycle unless the output stalls; stages: 1 setup, 16 cordic, 3 magnitude and
// error, 18 restoring divide steps (one quotient bit each), 3 multiply and sum.
// every stage holds its own valid bit and moves when the next stage frees up,
// so bubbles close under a stall and nothing is dropped or repeated.
// reset restores the register defaults and clears the captured radius.
`include "orbit_point_velocity_law_top_defines.svh"
module orbit_point_velocity_law_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  opvl_pkg::in_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output opvl_pkg::out_t                out_data_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [opvl_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  localparam int CW    = opvl_pkg::COORD_WIDTH;
  localparam int CS    = opvl_pkg::CORDIC_STAGES;
  localparam int NST   = opvl_pkg::NST;
  localparam int XY_W  = opvl_pkg::XY_W;
  localparam int D_W   = opvl_pkg::D_W;
  localparam int MAG_W = opvl_pkg::MAG_W;
  localparam int QB    = opvl_pkg::QB;
  localparam int REM_W = opvl_pkg::REM_W;
  localparam int UX_W  = opvl_pkg::UX_W;
  localparam int HI_W  = XY_W - 17 + 30;
  localparam int LO_W  = 46;
  localparam int PROD_W = HI_W + 17;
  localparam int PR_W  = UX_W + MAG_W + 1;
  localparam int TS_W  = UX_W + 16;
  localparam int HX_W  = PR_W - 16 + 17;
  localparam int FULL_W = HX_W + 17;
  localparam int RAD_W = FULL_W + 1 - 24;
  localparam int TG_W  = TS_W - 16;
  localparam int V_W   = RAD_W + 1;

  // configuration registers
  logic signed [CW-1:0] cx_q, cy_q;
  logic signed [15:0]   goal_q;
  logic [15:0]          gain_q;
  logic [14:0]          maxs_q, tol_q;
  opvl_pkg::reg_idx_e   idx;

  assign idx    = opvl_pkg::reg_idx_e'(paddr[opvl_pkg::ADDR_W-1:2]);
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q   <= opvl_pkg::CENTRE_RST;
      cy_q   <= opvl_pkg::CENTRE_RST;
      goal_q <= opvl_pkg::GOAL_RST;
      gain_q <= opvl_pkg::GAIN_RST;
      maxs_q <= opvl_pkg::MAXS_RST;
      tol_q  <= opvl_pkg::TOL_RST;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        opvl_pkg::REG_CENTRE_X: cx_q   <= pwdata[CW-1:0];
        opvl_pkg::REG_CENTRE_Y: cy_q   <= pwdata[CW-1:0];
        opvl_pkg::REG_GOAL:     goal_q <= pwdata[15:0];
        opvl_pkg::REG_GAIN:     gain_q <= pwdata[15:0];
        opvl_pkg::REG_MAXS:     maxs_q <= pwdata[14:0];
        opvl_pkg::REG_TOL:      tol_q  <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      opvl_pkg::REG_CENTRE_X: prdata = {{(32-CW){1'b0}}, cx_q};
      opvl_pkg::REG_CENTRE_Y: prdata = {{(32-CW){1'b0}}, cy_q};
      opvl_pkg::REG_GOAL:     prdata = {16'b0, goal_q};
      opvl_pkg::REG_GAIN:     prdata = {16'b0, gain_q};
      opvl_pkg::REG_MAXS:     prdata = {17'b0, maxs_q};
      opvl_pkg::REG_TOL:      prdata = {17'b0, tol_q};
      default:                prdata = '0;
    endcase
  end

  // stage valids and advance chain
  logic [NST-1:0] v_q;
  logic [NST:0]   adv;

  always_comb begin
    adv[NST] = out_ready_i;
    for (int k = NST - 1; k >= 0; k--) begin
      adv[k] = !v_q[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NST; k++) begin
        if (adv[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = v_q[NST-1];

  // setup: offset from centre, fold into right half plane
  opvl_pkg::cor_t cor_q [CS+1];
  opvl_pkg::cor_t cor_in;
  logic signed [D_W-1:0]  dx0, dy0;
  logic signed [XY_W-1:0] xs0, ys0;

  always_comb begin
    dx0 = $signed({in_data_i.robot_x[CW-1], in_data_i.robot_x}) - $signed({cx_q[CW-1], cx_q});
    dy0 = $signed({in_data_i.robot_y[CW-1], in_data_i.robot_y}) - $signed({cy_q[CW-1], cy_q});
    xs0 = XY_W'(dx0) <<< opvl_pkg::CORDIC_SHIFT;
    ys0 = XY_W'(dy0) <<< opvl_pkg::CORDIC_SHIFT;
    cor_in.dx   = dx0;
    cor_in.dy   = dy0;
    cor_in.zero = (dx0 == '0) && (dy0 == '0);
    if (xs0 < 0) begin
      cor_in.x   = -xs0;
      cor_in.y   = -ys0;
      cor_in.acc = 32'h8000_0000;
    end else begin
      cor_in.x   = xs0;
      cor_in.y   = ys0;
      cor_in.acc = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) cor_q[0] <= cor_in;
  end

  // vectoring cordic, one micro-rotation per stage
  for (genvar i = 0; i < CS; i++) begin : g_cor
    opvl_pkg::cor_t nxt;
    always_comb begin
      nxt = cor_q[i];
      if (cor_q[i].y > 0) begin
        nxt.x   = cor_q[i].x + (cor_q[i].y >>> i);
        nxt.y   = cor_q[i].y - (cor_q[i].x >>> i);
        nxt.acc = cor_q[i].acc + opvl_pkg::ATAN_TURNS[i];
      end else begin
        nxt.x   = cor_q[i].x - (cor_q[i].y >>> i);
        nxt.y   = cor_q[i].y + (cor_q[i].x >>> i);
        nxt.acc = cor_q[i].acc - opvl_pkg::ATAN_TURNS[i];
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv[i+1]) cor_q[i+1] <= nxt;
    end
  end

  // p1: gain correction partial products, rounded bearing
  logic [HI_W-1:0]       p1_hi_q;
  logic [LO_W-1:0]       p1_lo_q;
  logic [15:0]           p1_ang_q;
  logic signed [D_W-1:0] p1_dx_q, p1_dy_q;
  logic                  p1_zero_q;
  logic [31:0]           ang_sum;

  assign ang_sum = cor_q[CS].acc + 32'h0000_8000;

  always_ff @(posedge clk_i) begin
    if (adv[opvl_pkg::ST_P1]) begin
      p1_hi_q   <= cor_q[CS].x[XY_W-2:16] * opvl_pkg::INV_GAIN_Q30;
      p1_lo_q   <= cor_q[CS].x[15:0] * opvl_pkg::INV_GAIN_Q30;
      p1_ang_q  <= cor_q[CS].zero ? 16'd0 : ang_sum[31:16];
      p1_dx_q   <= cor_q[CS].dx;
      p1_dy_q   <= cor_q[CS].dy;
      p1_zero_q <= cor_q[CS].zero;
    end
  end

  // p2: distance, bearing error, heading, done
  logic [PROD_W-1:0]     prod;
  logic [15:0]           err, hdg;
  logic [16:0]           aerr;
  logic [MAG_W-1:0]      p2_mag_q;
  logic signed [D_W-1:0] p2_dx_q, p2_dy_q;
  logic                  p2_zero_q, p2_eneg_q, p2_done_q;
  logic [16:0]           p2_aerr_q;
  logic [15:0]           p2_hdg_q;

  always_comb begin
    prod = {1'b0, p1_hi_q, 16'b0} + PROD_W'(p1_lo_q)
         + (PROD_W'(1) << (opvl_pkg::MAG_SH - 1));
    err  = goal_q - p1_ang_q;
    hdg  = p1_ang_q + 16'h8000;
    aerr = err[15] ? (17'd0 - {err[15], err}) : {err[15], err};
  end

  always_ff @(posedge clk_i) begin
    if (adv[opvl_pkg::ST_P2]) begin
      p2_mag_q  <= p1_zero_q ? '0 : prod[opvl_pkg::MAG_SH +: MAG_W];
      p2_dx_q   <= p1_dx_q;
      p2_dy_q   <= p1_dy_q;
      p2_zero_q <= p1_zero_q;
      p2_eneg_q <= err[15];
      p2_aerr_q <= aerr;
      p2_hdg_q  <= hdg;
      p2_done_q <= aerr < {2'b0, tol_q};
    end
  end

  // p3: radius capture, tangential speed, divider setup
  logic [MAG_W-1:0] orbit_q, rad;
  logic             cap_q;
  logic [29:0]      spd_full;
  logic [14:0]      spd;
  logic [D_W-1:0]   adx, ady;
  opvl_pkg::div_t   div_q [QB+1];
  opvl_pkg::div_t   div_in;

  always_comb begin
    rad      = cap_q ? orbit_q : p2_mag_q;
    spd_full = p2_aerr_q * opvl_pkg::TANG_SPEED_K + 30'd32768;
    spd      = (15'(spd_full[29:16]) > maxs_q) ? maxs_q : 15'(spd_full[29:16]);
    adx      = p2_dx_q[D_W-1] ? D_W'(-p2_dx_q) : D_W'(p2_dx_q);
    ady      = p2_dy_q[D_W-1] ? D_W'(-p2_dy_q) : D_W'(p2_dy_q);
    div_in.rem_x   = (REM_W'(adx) << 16) + REM_W'(p2_mag_q >> 1);
    div_in.rem_y   = (REM_W'(ady) << 16) + REM_W'(p2_mag_q >> 1);
    div_in.q_x     = '0;
    div_in.q_y     = '0;
    div_in.mag     = p2_mag_q;
    div_in.sx      = p2_dx_q[D_W-1];
    div_in.sy      = p2_dy_q[D_W-1];
    div_in.diff    = $signed({1'b0, p2_mag_q}) - $signed({1'b0, rad});
    div_in.spd     = spd;
    div_in.eneg    = p2_eneg_q;
    div_in.heading = p2_hdg_q;
    div_in.done    = p2_done_q;
    div_in.zero    = p2_zero_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= 1'b0;
    end else if (adv[opvl_pkg::ST_P3] && v_q[opvl_pkg::ST_P2] && !cap_q) begin
      cap_q <= 1'b1;
    end
  end

  // first item after reset sets the orbit radius
  always_ff @(posedge clk_i) begin
    if (adv[opvl_pkg::ST_P3] && v_q[opvl_pkg::ST_P2] && !cap_q) orbit_q <= p2_mag_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv[opvl_pkg::ST_P3]) div_q[0] <= div_in;
  end

  // restoring divide, one quotient bit per stage, both axes side by side
  for (genvar k = 0; k < QB; k++) begin : g_div
    localparam int B = QB - 1 - k;
    opvl_pkg::div_t nxt;
    logic [REM_W-1:0] dv;
    always_comb begin
      nxt = div_q[k];
      dv  = REM_W'(div_q[k].mag) << B;
      if (div_q[k].rem_x >= dv) begin
        nxt.rem_x  = div_q[k].rem_x - dv;
        nxt.q_x[B] = 1'b1;
      end
      if (div_q[k].rem_y >= dv) begin
        nxt.rem_y  = div_q[k].rem_y - dv;
        nxt.q_y[B] = 1'b1;
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv[opvl_pkg::ST_P3 + k + 1]) div_q[k+1] <= nxt;
    end
  end

  // m1: signed unit vector times radius error and times speed
  opvl_pkg::div_t         dq;
  logic signed [UX_W-1:0] ux, uy, tx, ty;
  logic signed [PR_W-1:0] m1_prx_q, m1_pry_q;
  logic signed [TS_W-1:0] m1_tsx_q, m1_tsy_q;
  logic [14:0]            m1_spd_q;
  logic                   m1_eneg_q, m1_done_q, m1_zero_q;
  logic [15:0]            m1_hdg_q;

  always_comb begin
    dq = div_q[QB];
    ux = dq.sx ? -$signed({1'b0, dq.q_x}) : $signed({1'b0, dq.q_x});
    uy = dq.sy ? -$signed({1'b0, dq.q_y}) : $signed({1'b0, dq.q_y});
    // quarter turn toward the error
    tx = dq.eneg ? uy : -uy;
    ty = dq.eneg ? -ux : ux;
  end

  always_ff @(posedge clk_i) begin
    if (adv[opvl_pkg::ST_M1]) begin
      m1_prx_q  <= ux * dq.diff;
      m1_pry_q  <= uy * dq.diff;
      m1_tsx_q  <= tx * $signed({1'b0, dq.spd});
      m1_tsy_q  <= ty * $signed({1'b0, dq.spd});
      m1_spd_q  <= dq.spd;
      m1_eneg_q <= dq.eneg;
      m1_done_q <= dq.done;
      m1_zero_q <= dq.zero;
      m1_hdg_q  <= dq.heading;
    end
  end

  // m2: gain split in two partial products, tangential rounding
  logic signed [HX_W-1:0] m2_hix_q, m2_hiy_q;
  logic [31:0]            m2_lox_q, m2_loy_q;
  logic signed [TS_W:0]   tgx_r, tgy_r;
  logic signed [TG_W-1:0] m2_tgx_q, m2_tgy_q;
  logic [14:0]            m2_spd_q;
  logic                   m2_eneg_q, m2_done_q, m2_zero_q;
  logic [15:0]            m2_hdg_q;

  assign tgx_r = (TS_W+1)'(m1_tsx_q) + (TS_W+1)'(32768);
  assign tgy_r = (TS_W+1)'(m1_tsy_q) + (TS_W+1)'(32768);

  always_ff @(posedge clk_i) begin
    if (adv[opvl_pkg::ST_M2]) begin
      m2_hix_q  <= $signed(m1_prx_q[PR_W-1:16]) * $signed({1'b0, gain_q});
      m2_hiy_q  <= $signed(m1_pry_q[PR_W-1:16]) * $signed({1'b0, gain_q});
      m2_lox_q  <= m1_prx_q[15:0] * gain_q;
      m2_loy_q  <= m1_pry_q[15:0] * gain_q;
      m2_tgx_q  <= TG_W'(tgx_r >>> 16);
      m2_tgy_q  <= TG_W'(tgy_r >>> 16);
      m2_spd_q  <= m1_spd_q;
      m2_eneg_q <= m1_eneg_q;
      m2_done_q <= m1_done_q;
      m2_zero_q <= m1_zero_q;
      m2_hdg_q  <= m1_hdg_q;
    end
  end

  // m3: radial rounding, sum, saturation into the output register
  logic signed [FULL_W-1:0] fx, fy;
  logic signed [FULL_W:0]   nrx, nry;
  logic signed [V_W-1:0]    vx, vy;
  logic signed [15:0]       sx16, sy16;
  opvl_pkg::out_t           out_d, out_q;

  function automatic logic signed [15:0] sat16(input logic signed [V_W-1:0] v);
    logic signed [15:0] r;
    if (v > V_W'(32767))       r = 16'sh7fff;
    else if (v < -V_W'(32768)) r = -16'sh8000;
    else                       r = 16'(v);
    return r;
  endfunction

  always_comb begin
    fx   = (FULL_W'(m2_hix_q) <<< 16) + $signed({{(FULL_W-32){1'b0}}, m2_lox_q});
    fy   = (FULL_W'(m2_hiy_q) <<< 16) + $signed({{(FULL_W-32){1'b0}}, m2_loy_q});
    nrx  = -(FULL_W+1)'(fx) + (FULL_W+1)'(1 << 23);
    nry  = -(FULL_W+1)'(fy) + (FULL_W+1)'(1 << 23);
    vx   = V_W'(RAD_W'(nrx >>> 24)) + V_W'(m2_tgx_q);
    vy   = V_W'(RAD_W'(nry >>> 24)) + V_W'(m2_tgy_q);
    sx16 = sat16(vx);
    sy16 = sat16(vy);
    out_d.heading  = m2_hdg_q;
    out_d.done_res = m2_done_q;
    if (m2_done_q) begin
      out_d.vel_x = '0;
      out_d.vel_y = '0;
    end else if (m2_zero_q) begin
      // at the centre: straight along y
      out_d.vel_x = '0;
      out_d.vel_y = m2_eneg_q ? -$signed({1'b0, m2_spd_q}) : $signed({1'b0, m2_spd_q});
    end else begin
      out_d.vel_x = sx16;
      out_d.vel_y = sy16;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[opvl_pkg::ST_M3]) out_q <= out_d;
  end

  assign out_data_o = out_q;

  `OPVL_ASSERT(a_done_zero, out_valid_o && out_data_o.done_res |-> out_data_o.vel_x == 16'sd0 && out_data_o.vel_y == 16'sd0, "done item with nonzero velocity")
  `OPVL_ASSERT(a_cap_hold, cap_q |=> cap_q, "radius capture flag dropped")
  `OPVL_ASSERT(a_enter, in_valid_i && in_ready_o |=> v_q[0], "accepted item missing from first stage")
  `OPVL_ASSERT(a_div_rem, v_q[opvl_pkg::ST_P3 + QB] && !div_q[QB].zero && div_q[QB].mag != '0 |-> div_q[QB].rem_x < REM_W'(div_q[QB].mag), "divider remainder out of range")
  `OPVL_ASSERT_NR(a_rst_cap, !rst_ni |=> !cap_q, "radius captured during reset")

endmodule

@@ tb/orbit_law_checker.sv @@
// checker for the orbit point velocity law block: predicts each velocity item and compares
`timescale 1ns / 1ps
module orbit_law_checker (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_ready_i,
  input  opvl_pkg::in_t   in_data_i,
  input  logic            out_valid_i,
  input  logic            out_ready_i,
  input  opvl_pkg::out_t  out_data_i,
  input  logic            psel_i,
  input  logic            penable_i,
  input  logic            pwrite_i,
  input  logic [opvl_pkg::ADDR_W-1:0] paddr_i,
  input  logic [31:0]     pwdata_i,
  output int              fail_count_o,
  output int              pending_o
);
  localparam logic [31:0] ATAN_TAB [16] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861};

  logic signed [15:0] cx, cy, goal;
  logic [15:0] gain;
  logic [14:0] vmax, tol;
  longint radius;
  bit captured;
  opvl_pkg::out_t vel_expected [$];

  assign pending_o = vel_expected.size();

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_div(longint n, longint d);
    if (n >= 0) return (n + d / 2) / d;
    return -((-n + d / 2) / d);
  endfunction

  function automatic longint clamp16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic opvl_pkg::out_t orbit_velocity(opvl_pkg::in_t p);
    longint dx, dy, x, y, nx, ny, bearing, dist_mm, err, aerr, spd, vx, vy;
    longint ux, uy, drg, tx, ty;
    logic [31:0] acc;
    logic [63:0] prod;
    logic [15:0] w;
    opvl_pkg::out_t r;
    dx = longint'(p.robot_x) - longint'(cx);
    dy = longint'(p.robot_y) - longint'(cy);
    if (dx == 0 && dy == 0) begin
      bearing = 0;
      dist_mm = 0;
    end else begin
      x = dx <<< opvl_pkg::CORDIC_SHIFT;
      y = dy <<< opvl_pkg::CORDIC_SHIFT;
      acc = 0;
      if (x < 0) begin
        x = -x;
        y = -y;
        acc = 32'h8000_0000;
      end
      for (int i = 0; i < 16; i++) begin
        if (y > 0) begin
          nx = x + floor_shift(y, i);
          ny = y - floor_shift(x, i);
          acc += ATAN_TAB[i];
        end else begin
          nx = x - floor_shift(y, i);
          ny = y + floor_shift(x, i);
          acc -= ATAN_TAB[i];
        end
        x = nx;
        y = ny;
      end
      w = 16'((33'(acc) + 33'h8000) >> 16);
      bearing = longint'($signed(w));
      prod = 64'(x) * 64'd652032875 + (64'd1 << (29 + opvl_pkg::CORDIC_SHIFT));
      dist_mm = longint'(prod >> (30 + opvl_pkg::CORDIC_SHIFT));
    end
    if (!captured) begin
      radius = dist_mm > 131071 ? 131071 : dist_mm;
      captured = 1;
    end
    w = 16'(goal - bearing);
    err = longint'($signed(w));
    aerr = err < 0 ? -err : err;
    w = 16'(bearing + 32768);
    r.heading = $signed(w);
    if (aerr < longint'(tol)) begin
      r.vel_x = '0;
      r.vel_y = '0;
      r.done_res = 1'b1;
      return r;
    end
    spd = (aerr * 3770 + 32768) >>> 16;
    if (spd > longint'(vmax)) spd = longint'(vmax);
    if (dist_mm == 0) begin
      vx = 0;
      vy = err >= 0 ? spd : -spd;
    end else begin
      ux = round_div(dx * 65536, dist_mm);
      uy = round_div(dy * 65536, dist_mm);
      drg = (dist_mm - radius) * longint'(gain);
      tx = err >= 0 ? -uy : uy;
      ty = err >= 0 ? ux : -ux;
      vx = ((-ux * drg + (64'sd1 <<< 23)) >>> 24) + ((tx * spd + 32768) >>> 16);
      vy = ((-uy * drg + (64'sd1 <<< 23)) >>> 24) + ((ty * spd + 32768) >>> 16);
    end
    r.vel_x = 16'(clamp16(vx));
    r.vel_y = 16'(clamp16(vy));
    r.done_res = 1'b0;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    opvl_pkg::out_t want;
    if (!rst_ni) begin
      cx <= '0;
      cy <= '0;
      goal <= '0;
      gain <= 16'd7680;
      vmax <= 15'd500;
      tol <= 15'd1043;
      radius = 0;
      captured = 0;
      fail_count_o <= 0;
      vel_expected.delete();
    end else begin
      if (psel_i && penable_i && pwrite_i) begin
        case (opvl_pkg::reg_idx_e'(paddr_i[4:2]))
          opvl_pkg::REG_CENTRE_X: cx <= pwdata_i[15:0];
          opvl_pkg::REG_CENTRE_Y: cy <= pwdata_i[15:0];
          opvl_pkg::REG_GOAL:     goal <= pwdata_i[15:0];
          opvl_pkg::REG_GAIN:     gain <= pwdata_i[15:0];
          opvl_pkg::REG_MAXS:     vmax <= pwdata_i[14:0];
          opvl_pkg::REG_TOL:      tol <= pwdata_i[14:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (vel_expected.size() == 0) begin
          if (fail_count_o < 10) $display("unexpected item %p", out_data_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = vel_expected.pop_front();
          if (want !== out_data_i) begin
            if (fail_count_o < 10)
              $display("mismatch exp vx=%0d vy=%0d hd=%0d dn=%0d got vx=%0d vy=%0d hd=%0d dn=%0d",
                       want.vel_x, want.vel_y, want.heading, want.done_res,
                       out_data_i.vel_x, out_data_i.vel_y, out_data_i.heading,
                       out_data_i.done_res);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (in_valid_i && in_ready_i) vel_expected.push_back(orbit_velocity(in_data_i));
    end
  end
endmodule

@@ tb/tb_orbit_point_velocity_law_top.sv @@
// testbench top for the orbit point velocity law block: stimulus, register writes and verdict
`timescale 1ns / 1ps
module tb_orbit_point_velocity_law_top;
  logic clk_i = 0;
  logic rst_ni = 0;
  logic in_valid_i = 0;
  logic in_ready_o;
  opvl_pkg::in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 0;
  opvl_pkg::out_t out_data_o;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [opvl_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  int fail_count, pending;
  logic hold_go = 0;
  int hold_cnt = 0;
  longint cycles = 0;

  always #5 clk_i = ~clk_i;

  orbit_point_velocity_law_top dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  orbit_law_checker chk (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_data_i(out_data_o),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr),
    .pwdata_i(pwdata), .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("FAIL");
      $finish;
    end
  end

  // receiver: random stall pattern, plus one long hold-off once requested
  always @(posedge clk_i) begin
    if (hold_go && hold_cnt < 400) begin
      out_ready_i <= 0;
      hold_cnt <= hold_cnt + 1;
    end else begin
      out_ready_i <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 9) == 0);
    end
  end

  task automatic write_reg(opvl_pkg::reg_idx_e idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= opvl_pkg::ADDR_W'(idx) << 2;
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
  endtask

  task automatic send_point(logic [15:0] x, logic [15:0] y);
    in_valid_i <= 1;
    in_data_i <= '{robot_x: x, robot_y: y};
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic pause_sender();
    in_valid_i <= 0;
    repeat ($urandom_range(1, 12)) @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 0;
    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic random_burst(int n, int span);
    int burst;
    burst = $urandom_range(1, 20);
    for (int i = 0; i < n; i++) begin
      if (span == 0) send_point(16'($urandom), 16'($urandom));
      else send_point(16'($signed($urandom_range(0, 2 * span)) - span),
                      16'($signed($urandom_range(0, 2 * span)) - span));
      if (--burst == 0) begin
        burst = $urandom_range(1, 20);
        if ($urandom_range(0, 2) != 0) pause_sender();
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // first item captures the radius
    send_point(16'd1000, 16'd0);
    send_point(16'd0, 16'd1000);
    send_point(16'd0, 16'd0);
    send_point(16'h7fff, 16'h7fff);
    send_point(16'h8000, 16'h8000);
    send_point(16'h7fff, 16'h8000);
    send_point(16'h8000, 16'h7fff);
    send_point(16'hffff, 16'h0000);
    send_point(16'd1000, 16'd10);
    send_point(16'd1000, 16'hfff6);
    send_point(16'hfc18, 16'd0);
    drain();
    write_reg(opvl_pkg::REG_CENTRE_X, 32'hffff_8000);
    write_reg(opvl_pkg::REG_CENTRE_Y, 32'h0000_7fff);
    write_reg(opvl_pkg::REG_GOAL, 32'h0000_8000);
    write_reg(opvl_pkg::REG_GAIN, 32'h0000_ffff);
    write_reg(opvl_pkg::REG_MAXS, 32'h0000_7fff);
    write_reg(opvl_pkg::REG_TOL, 32'h0);
    send_point(16'h8000, 16'h7fff);
    send_point(16'h7fff, 16'h8000);
    send_point(16'd0, 16'd0);
    send_point(16'h7fff, 16'h7fff);
    drain();
    write_reg(opvl_pkg::REG_TOL, 32'h0000_7fff);
    send_point(16'd123, 16'd456);
    send_point(16'h8000, 16'h8000);
    drain();
    write_reg(opvl_pkg::REG_GAIN, 32'h0);
    write_reg(opvl_pkg::REG_MAXS, 32'h0);
    write_reg(opvl_pkg::REG_TOL, 32'd1043);
    send_point(16'd500, 16'hfe00);
    send_point(16'h8000, 16'h7fff);
    drain();
    // random phases with varied settings
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(opvl_pkg::REG_CENTRE_X, $urandom);
      write_reg(opvl_pkg::REG_CENTRE_Y, $urandom);
      write_reg(opvl_pkg::REG_GOAL, $urandom);
      write_reg(opvl_pkg::REG_GAIN, ph == 0 ? 32'd7680 : $urandom);
      write_reg(opvl_pkg::REG_MAXS, $urandom);
      write_reg(opvl_pkg::REG_TOL, ph[0] ? $urandom_range(0, 4000) : $urandom);
      if (ph == 2) begin
        hold_go <= 1'b1;
        random_burst(80, 0);
      end
      random_burst(100, 0);
      random_burst(100, 3000);
      drain();
    end
    write_reg(opvl_pkg::REG_CENTRE_X, 0);
    write_reg(opvl_pkg::REG_CENTRE_Y, 0);
    write_reg(opvl_pkg::REG_TOL, 32'd200);
    random_burst(50, 1500);
    drain();
    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
